FILE: hdl/rpn_pkg.sv
// Shared types and constants for the postfix expression evaluator.
// No dependencies; every other file in hdl/ imports this package.
package rpn_pkg;

  localparam int StackDepthDefault = 32;
  localparam int DataWidth = 64;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic [2:0]                  status;
  } out_item_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_BADCHAR   = 3'd3;
  localparam logic [2:0] ST_BADEXPR   = 3'd4;
  localparam logic [2:0] ST_DIVZERO   = 3'd5;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_CHAR,
    S_OPRD,
    S_ALU,
    S_FIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } alu_ctrl_t;

endpackage

FILE: hdl/postfix_expression_evaluator.sv
// Postfix expression evaluator. Characters arrive one request at a time on the in_ channel;
// a digit is folded into the literal in S_DECODE; a blank, a stray character or a digit
// run's end also passes S_CHAR, a + or - adds S_OPRD for the stack read of the second
// operand, and a * or / waits in S_ALU, as the shared multiply/divide unit retires one bit
// per cycle. Once an error is latched, further characters are skipped in S_DECODE. The
// request flagged last then goes to S_EMIT, via S_FIN when it ends a literal, to form the
// result request on the out_ channel, waiting for the previous result to be taken. The top
// value lives in a register and the rest of the stack in a single-port-write memory, so an
// operator needs just one memory read. No clearing pass is needed after reset.
// Depends on rpn_pkg, rpn_stack_mem and rpn_alu.
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::StackDepthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpn_pkg::out_item_t out_data
);
  import rpn_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  state_t               state_r, state_nxt;
  logic [7:0]           ch_r, ch_nxt;
  logic                 last_r, last_nxt;
  logic [DataWidth-1:0] top_r, top_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [DataWidth-1:0] num_r, num_nxt;
  logic                 in_num_r, in_num_nxt;
  logic [2:0]           err_r, err_nxt;
  out_item_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [DataWidth-1:0] wr_data, rd_data;
  logic [CW-1:0]        cnt_m1, cnt_m2;
  logic [3:0]           digit;
  logic                 is_digit, is_op, is_blank;
  alu_ctrl_t            alu_ctrl;
  logic                 alu_done;
  logic [DataWidth-1:0] alu_res;

  rpn_stack_mem #(.Depth(STACK_DEPTH)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (alu_ctrl),
    .opa   (top_r),
    .opb   (rd_data),
    .done  (alu_done),
    .result(alu_res)
  );

  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);
  assign wr_addr  = cnt_m1[AW-1:0];
  assign rd_addr  = cnt_m2[AW-1:0];
  assign wr_data  = top_r;
  assign digit    = 4'(ch_r - CH_ZERO);
  assign is_digit = ch_r inside {[CH_ZERO:CH_NINE]};
  assign is_op    = ch_r inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
  assign is_blank = ch_r inside {CH_SPACE, CH_TAB};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    top_nxt       = top_r;
    count_nxt     = count_r;
    num_nxt       = num_r;
    in_num_nxt    = in_num_r;
    err_nxt       = err_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    alu_ctrl      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ch_nxt    = in_data.ch;
          last_nxt  = in_data.last;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (err_r != ST_OK) begin
          // After the first error the rest of the expression is skipped.
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end else if (is_digit) begin
          num_nxt    = (num_r << 3) + (num_r << 1) + DataWidth'(digit);
          in_num_nxt = 1'b1;
          state_nxt  = last_r ? S_FIN : S_IDLE;
        end else begin
          // Any other character first ends a pending literal.
          if (in_num_r) begin
            in_num_nxt = 1'b0;
            num_nxt    = '0;
            if (count_r == CW'(STACK_DEPTH)) begin
              err_nxt = ST_OVERFLOW;
            end else begin
              wr_en     = (count_r != '0);
              top_nxt   = num_r;
              count_nxt = count_r + CW'(1);
            end
          end
          state_nxt = S_CHAR;
        end
      end

      S_CHAR: begin
        state_nxt = last_r ? S_EMIT : S_IDLE;
        if (err_r == ST_OK && !is_blank) begin
          if (is_op) begin
            if (count_r < CW'(2)) begin
              err_nxt = ST_UNDERFLOW;
            end else begin
              rd_en     = 1'b1;
              state_nxt = S_OPRD;
            end
          end else begin
            err_nxt = ST_BADCHAR;
          end
        end
      end

      S_OPRD: begin
        // rd_data holds b, the value below the top; top_r holds a.
        state_nxt = last_r ? S_EMIT : S_IDLE;
        case (ch_r)
          CH_PLUS: begin
            top_nxt   = rd_data + top_r;
            count_nxt = cnt_m1;
          end
          CH_MINUS: begin
            top_nxt   = rd_data - top_r;
            count_nxt = cnt_m1;
          end
          CH_STAR: begin
            alu_ctrl.start = 1'b1;
            state_nxt      = S_ALU;
          end
          default: begin
            if (top_r == '0) begin
              err_nxt = ST_DIVZERO;
            end else begin
              alu_ctrl.start  = 1'b1;
              alu_ctrl.is_div = 1'b1;
              state_nxt       = S_ALU;
            end
          end
        endcase
      end

      S_ALU: begin
        if (alu_done) begin
          top_nxt   = alu_res;
          count_nxt = cnt_m1;
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end

      S_FIN: begin
        // The expression ended inside a literal: push it now.
        in_num_nxt = 1'b0;
        num_nxt    = '0;
        if (count_r == CW'(STACK_DEPTH)) begin
          err_nxt = ST_OVERFLOW;
        end else begin
          wr_en     = (count_r != '0);
          top_nxt   = num_r;
          count_nxt = count_r + CW'(1);
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          if (err_r != ST_OK) begin
            out_nxt.value  = '0;
            out_nxt.status = err_r;
          end else if (count_r == CW'(1)) begin
            out_nxt.value  = top_r;
            out_nxt.status = ST_OK;
          end else begin
            out_nxt.value  = '0;
            out_nxt.status = ST_BADEXPR;
          end
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          num_nxt       = '0;
          in_num_nxt    = 1'b0;
          err_nxt       = ST_OK;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      num_r       <= '0;
      in_num_r    <= 1'b0;
      err_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      num_r       <= num_nxt;
      in_num_r    <= in_num_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r   <= ch_nxt;
    last_r <= last_nxt;
    top_r  <= top_nxt;
    out_r  <= out_nxt;
  end

endmodule

FILE: hdl/rpn_stack_mem.sv
// Operand stack storage: one write port and one registered read port.
// Depends on rpn_pkg for the data width.
module rpn_stack_mem #(
  parameter int Depth = rpn_pkg::StackDepthDefault,
  localparam int AW = $clog2(Depth)
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [AW-1:0]                  wr_addr,
  input  logic [rpn_pkg::DataWidth-1:0]  wr_data,
  input  logic                           rd_en,
  input  logic [AW-1:0]                  rd_addr,
  output logic [rpn_pkg::DataWidth-1:0]  rd_data
);
  import rpn_pkg::*;

  logic [DataWidth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/rpn_alu.sv
// Iterative multiply (low 64 bits) and signed truncating divide, one bit per cycle.
// Depends on rpn_pkg for the control struct and data width.
module rpn_alu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rpn_pkg::alu_ctrl_t            ctrl,
  input  logic [rpn_pkg::DataWidth-1:0] opa,
  input  logic [rpn_pkg::DataWidth-1:0] opb,
  output logic                          done,
  output logic [rpn_pkg::DataWidth-1:0] result
);
  import rpn_pkg::*;

  localparam int CntW = $clog2(DataWidth);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 div_r, div_nxt;
  logic                 neg_r, neg_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [DataWidth-1:0] acc_r, acc_nxt;
  logic [DataWidth-1:0] sh_r, sh_nxt;
  logic [DataWidth-1:0] md_r, md_nxt;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] mag_a, mag_b;

  always_comb begin
    mag_a    = opa[DataWidth-1] ? (~opa + 1'b1) : opa;
    mag_b    = opb[DataWidth-1] ? (~opb + 1'b1) : opb;
    trial    = {acc_r, sh_r[DataWidth-1]} - {1'b0, md_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    md_nxt   = md_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      div_nxt  = ctrl.is_div;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      neg_nxt  = opa[DataWidth-1] ^ opb[DataWidth-1];
      if (ctrl.is_div) begin
        // Shift the dividend magnitude out MSB first into the remainder.
        sh_nxt = mag_b;
        md_nxt = mag_a;
      end else begin
        sh_nxt = opa;
        md_nxt = opb;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!trial[DataWidth]) begin
          acc_nxt = trial[DataWidth-1:0];
          sh_nxt  = {sh_r[DataWidth-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[DataWidth-2:0], sh_r[DataWidth-1]};
          sh_nxt  = {sh_r[DataWidth-2:0], 1'b0};
        end
      end else begin
        if (sh_r[0]) begin
          acc_nxt = acc_r + md_r;
        end
        sh_nxt = {1'b0, sh_r[DataWidth-1:1]};
        md_nxt = {md_r[DataWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DataWidth - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    md_r  <= md_nxt;
  end

  assign done   = done_r;
  assign result = div_r ? (neg_r ? (~sh_r + 1'b1) : sh_r) : acc_r;

endmodule
